// ----- rtl/core/cpd_pkg.sv -----
package cpd_pkg;

    localparam int unsigned NUM_LANES  = 8;
    localparam int unsigned TAIL_BYTES = 4;
    localparam int unsigned TAIL_SLOTS = NUM_LANES - TAIL_BYTES + 1;

    // Head marker 55 AA 55 AA and tail marker 66 CC 66 CC, byte 0 lowest
    localparam logic [31:0] HEAD_MARK = 32'hAA55_AA55;
    localparam logic [31:0] TAIL_MARK = 32'hCC66_CC66;

    localparam logic [3:0] FULL_LEN = 4'(NUM_LANES);

    typedef enum logic [0:0] {
        CFG_COMMAND_CODE = 1'b0,
        CFG_SCRAMBLE_KEY = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [3:0]  frame_len;
        logic [63:0] frame_bytes;
    } frame_t;

    typedef struct packed {
        logic [63:0] payload_bytes;
        logic [3:0]  payload_count;
        logic [15:0] payload_offset;
        logic        head_found;
        logic        packet_done;
        logic        packet_dropped;
    } result_t;

endpackage

// ----- rtl/core/cpd_in_reg.sv -----
module cpd_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  cpd_pkg::frame_t in_frame,
    input  logic            take,
    output logic            frame_valid,
    output cpd_pkg::frame_t frame_q
);
    import cpd_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;
    logic   accept;

    // Holding register frees up in the same cycle the engine takes it
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg <= in_frame;
        end
    end

    assign frame_valid = valid_reg;
    assign frame_q     = frame_reg;

endmodule

// ----- rtl/core/cpd_engine.sv -----
module cpd_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [0:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             frame_valid,
    input  cpd_pkg::frame_t  frame_q,
    output logic             take,
    output logic             out_valid,
    input  logic             out_stall,
    output cpd_pkg::result_t result
);
    import cpd_pkg::*;

    logic [15:0] command_code_reg;
    logic [7:0]  scramble_key_reg;

    logic        in_packet_reg;
    logic        in_packet_next;
    logic [15:0] packet_length_reg;
    logic [15:0] packet_length_next;
    logic [15:0] write_position_reg;
    logic [15:0] write_position_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     result_reg;
    result_t     result_next;

    logic [3:0]  dlc;
    logic [15:0] remaining;
    logic [3:0]  count;
    logic [15:0] pos_after;
    logic [31:0] tail_word;
    logic        is_head;
    logic        closing;
    logic        tail_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_code_reg <= '0;
            scramble_key_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_COMMAND_CODE: command_code_reg <= cfg_data;
                CFG_SCRAMBLE_KEY: scramble_key_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign take = frame_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        dlc = (frame_q.frame_len > FULL_LEN) ? FULL_LEN : frame_q.frame_len;
        remaining = packet_length_reg - write_position_reg;
        count = (remaining < {12'd0, dlc}) ? remaining[3:0] : dlc;
        pos_after = write_position_reg + {12'd0, count};

        is_head = (dlc == FULL_LEN) && (frame_q.frame_bytes[31:0] == HEAD_MARK)
                  && (frame_q.frame_bytes[47:32] == command_code_reg);

        // Last four bytes of the frame, wherever it ends
        tail_word = '0;
        for (int t = 0; t < TAIL_SLOTS; t++)
        begin
            if (dlc == 4'(t + TAIL_BYTES))
            begin
                tail_word = frame_q.frame_bytes[t*8 +: 32];
            end
        end
        tail_ok = ((dlc - count) >= 4'(TAIL_BYTES)) && (tail_word == TAIL_MARK);
        closing = in_packet_reg && (pos_after == packet_length_reg) && (count < dlc);

        in_packet_next      = in_packet_reg;
        packet_length_next  = packet_length_reg;
        write_position_next = write_position_reg;
        result_next         = '0;

        if (!in_packet_reg)
        begin
            if (is_head)
            begin
                in_packet_next         = 1'b1;
                packet_length_next     = frame_q.frame_bytes[63:48];
                write_position_next    = '0;
                result_next.head_found = 1'b1;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                if (4'(k) < count)
                begin
                    result_next.payload_bytes[k*8 +: 8] =
                        frame_q.frame_bytes[k*8 +: 8] ^ scramble_key_reg;
                end
            end
            result_next.payload_count  = count;
            result_next.payload_offset = (count == 4'd0) ? 16'd0 : write_position_reg;
            write_position_next        = pos_after;
            if (closing)
            begin
                in_packet_next = 1'b0;
                if (tail_ok)
                begin
                    result_next.packet_done = 1'b1;
                end
                else
                begin
                    result_next.packet_dropped = 1'b1;
                    write_position_next        = '0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg      <= 1'b0;
            packet_length_reg  <= '0;
            write_position_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                in_packet_reg      <= in_packet_next;
                packet_length_reg  <= packet_length_next;
                write_position_reg <= write_position_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({result_reg.head_found, result_reg.packet_done,
                                    result_reg.packet_dropped}))
        else $error("more than one packet event in one result");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_packet_reg |-> (write_position_reg <= packet_length_reg))
        else $error("write position beyond packet length");

    a_head_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.head_found) |-> (result_reg.payload_count == 4'd0))
        else $error("head frame carried payload");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.payload_count == 4'd0)
        |-> (result_reg.payload_offset == 16'd0 && result_reg.payload_bytes == 64'd0))
        else $error("empty result with non-zero payload fields");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.payload_count <= FULL_LEN))
        else $error("payload count above lane count");

    a_state_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(in_packet_reg) && $stable(write_position_reg))
        else $error("packet state moved without a request");

endmodule

// ----- rtl/core/can_packet_deframer.sv -----
// Channel   Direction  Handshake             Payload
// in        to block   in_valid / in_stall   frame_len, frame_bytes
// out       from block out_valid / out_stall payload_bytes, payload_count, payload_offset,
//                                            head_found, packet_done, packet_dropped
// cfg       to block   cfg_write_en          cfg_index, cfg_data
//
// One request per cycle sustained while out is not stalled; each request gives one result
// (through the input register, then the packet logic into the result register).
// Packet state updates as a request leaves the input register, so it is exact
// for back-to-back requests.
// Reset clears packet state, command code and key; payload registers are not reset.
// A stall on out holds the result; the input register then fills and in_stall rises.
module can_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  frame_len,
    input  logic [63:0] frame_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] payload_bytes,
    output logic [3:0]  payload_count,
    output logic [15:0] payload_offset,
    output logic        head_found,
    output logic        packet_done,
    output logic        packet_dropped
);
    import cpd_pkg::*;

    frame_t  in_frame;
    frame_t  frame_q;
    logic    frame_valid;
    logic    take;
    result_t result;

    assign in_frame.frame_len   = frame_len;
    assign in_frame.frame_bytes = frame_bytes;

    cpd_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_frame    (in_frame),
        .take        (take),
        .frame_valid (frame_valid),
        .frame_q     (frame_q)
    );

    cpd_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_valid  (frame_valid),
        .frame_q      (frame_q),
        .take         (take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result)
    );

    assign payload_bytes  = result.payload_bytes;
    assign payload_count  = result.payload_count;
    assign payload_offset = result.payload_offset;
    assign head_found     = result.head_found;
    assign packet_done    = result.packet_done;
    assign packet_dropped = result.packet_dropped;

endmodule

// ----- dv/testbench.sv -----
module testbench;
    import cpd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_MISMATCH_REPORTS = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [0:0]  cfg_index = CFG_COMMAND_CODE;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  frame_len = '0;
    logic [63:0] frame_bytes = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] payload_bytes;
    logic [3:0]  payload_count;
    logic [15:0] payload_offset;
    logic        head_found;
    logic        packet_done;
    logic        packet_dropped;

    can_packet_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_len      (frame_len),
        .frame_bytes    (frame_bytes),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_bytes  (payload_bytes),
        .payload_count  (payload_count),
        .payload_offset (payload_offset),
        .head_found     (head_found),
        .packet_done    (packet_done),
        .packet_dropped (packet_dropped)
    );

    always #10 clk = ~clk;

    // predictor copy of the registers and packet state
    logic [15:0] model_cmd = '0;
    logic [7:0]  model_key = '0;
    logic        model_open = 1'b0;
    logic [15:0] model_len = '0;
    logic [15:0] model_pos = '0;

    result_t expected_results[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned frames_sent = 0;
    int unsigned frames_used = 0;
    int unsigned results_seen = 0;
    int unsigned heads_seen = 0;
    int unsigned packets_done = 0;
    int unsigned packets_dropped = 0;
    int unsigned mismatches = 0;
    int unsigned errors = 0;

    function automatic result_t deframe_frame(logic [3:0] len_in, logic [63:0] data);
        result_t r;
        int unsigned n;
        int unsigned i;
        int unsigned cnt;
        logic tail_ok;
        r = '0;
        n = (len_in > 4'd8) ? 8 : len_in;
        cnt = 0;
        if (!model_open) begin
            if (n == 8 && data[31:0] == HEAD_MARK && data[47:32] == model_cmd) begin
                model_len = data[63:48];
                model_pos = '0;
                model_open = 1'b1;
                r.head_found = 1'b1;
            end
        end
        else begin
            i = 0;
            r.payload_offset = model_pos;
            while (i < n && model_pos < model_len) begin
                r.payload_bytes[cnt*8 +: 8] = data[i*8 +: 8] ^ model_key;
                cnt++;
                i++;
                model_pos = model_pos + 16'd1;
            end
            r.payload_count = 4'(cnt);
            if (cnt == 0)
                r.payload_offset = '0;
            // tail needs four bytes clear of the payload, taken from the frame end
            if (model_pos == model_len && i < n) begin
                tail_ok = 1'b0;
                if (n - i >= 4)
                    tail_ok = (data[(n-4)*8 +: 32] == TAIL_MARK);
                if (tail_ok) begin
                    r.packet_done = 1'b1;
                end
                else begin
                    r.packet_dropped = 1'b1;
                    model_pos = '0;
                end
                model_open = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_bytes();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] head_bytes(logic [15:0] plen, logic [15:0] cmd);
        return {plen, cmd, HEAD_MARK};
    endfunction

    // a full frame is sometimes sent with an oversized length code
    function automatic logic [3:0] full_len();
        if ($urandom_range(0, 3) == 0)
            return 4'($urandom_range(9, 15));
        return FULL_LEN;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // accepted request: predict its result
    always @(posedge clk)
    begin
        result_t r;
        logic was_open;
        if (rst_n && in_valid && !in_stall)
        begin
            was_open = model_open;
            r = deframe_frame(frame_len, frame_bytes);
            expected_results.push_back(r);
            frames_sent++;
            if (was_open || r.head_found)
                frames_used++;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {payload_bytes, payload_count, payload_offset,
                   head_found, packet_done, packet_dropped};
            results_seen++;
            heads_seen += got.head_found;
            packets_done += got.packet_done;
            packets_dropped += got.packet_dropped;
            if (expected_results.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= MAX_MISMATCH_REPORTS)
                    $display("unexpected result at cycle %0d: bytes=%h", cycle_count,
                             got.payload_bytes);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= MAX_MISMATCH_REPORTS)
                    begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  exp bytes=%h cnt=%0d off=%0d head=%b done=%b drop=%b",
                                 want.payload_bytes, want.payload_count,
                                 want.payload_offset, want.head_found,
                                 want.packet_done, want.packet_dropped);
                        $display("  got bytes=%h cnt=%0d off=%0d head=%b done=%b drop=%b",
                                 got.payload_bytes, got.payload_count,
                                 got.payload_offset, got.head_found,
                                 got.packet_done, got.packet_dropped);
                    end
                end
            end
        end
    end

    task automatic send_frame(logic [3:0] len, logic [63:0] data);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_len <= len;
        frame_bytes <= data;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(logic [15:0] cmd, logic [7:0] key);
        cfg_write_en <= 1'b1;
        cfg_index <= CFG_COMMAND_CODE;
        cfg_data <= cmd;
        @(posedge clk);
        cfg_index <= CFG_SCRAMBLE_KEY;
        cfg_data <= {8'($urandom), key};
        @(posedge clk);
        cfg_write_en <= 1'b0;
        model_cmd = cmd;
        model_key = key;
        @(posedge clk);
    endtask

    task automatic send_packet(int unsigned plen, bit good_tail);
        int unsigned left;
        int unsigned n;
        int unsigned dlc;
        logic [63:0] data;
        send_frame(full_len(), head_bytes(16'(plen), model_cmd));
        left = plen;
        // a body frame may end exactly on the length, leaving the packet open
        while (left > 4 || (left > 0 && $urandom_range(0, 3) == 0))
        begin
            n = $urandom_range(1, (left < 8) ? left : 8);
            send_frame((n == 8) ? full_len() : 4'(n), rand_bytes());
            left -= n;
        end
        data = rand_bytes();
        if (good_tail)
        begin
            dlc = left + $urandom_range(4, 8 - left);
            data[(dlc-4)*8 +: 32] = TAIL_MARK;
        end
        else
        begin
            dlc = $urandom_range(left + 1, 8);
            if (dlc >= 4 && $urandom_range(0, 1) == 1)
            begin
                data[(dlc-4)*8 +: 32] = TAIL_MARK;
                data[(dlc-4)*8 + $urandom_range(0, 31)] ^= 1'b1;
            end
        end
        send_frame((dlc == 8) ? full_len() : 4'(dlc), data);
    endtask

    task automatic send_noise();
        logic [63:0] data;
        data = rand_bytes();
        case ($urandom_range(0, 3))
            0: data[31:0] = HEAD_MARK;
            1: data = head_bytes(16'($urandom), model_cmd);
            default: ;
        endcase
        send_frame(4'($urandom_range(0, 15)), data);
    endtask

    task automatic test_directed();
        apply_config(16'h1234, 8'h5A);
        send_frame(4'd8, rand_bytes());
        send_frame(4'd8, head_bytes(16'd5, 16'h1235));
        send_frame(4'd7, head_bytes(16'd5, 16'h1234));
        // body ends on the length, tail arrives alone in the next frame
        send_frame(4'd8, head_bytes(16'd5, 16'h1234));
        send_frame(4'd5, 64'h8899_AABB_CCDD_EEFF);
        send_frame(4'd4, {32'h0, TAIL_MARK});
        // zero-length packet: empty frame keeps it open, then tail only
        send_frame(4'd15, head_bytes(16'd0, 16'h1234));
        send_frame(4'd0, rand_bytes());
        send_frame(4'd8, {TAIL_MARK, 32'h0102_0304});
        send_frame(4'd8, head_bytes(16'd3, 16'h1234));
        send_frame(4'd8, {TAIL_MARK, 8'h77, 24'hABCDEF});
        send_frame(4'd8, head_bytes(16'd10, 16'h1234));
        send_frame(4'd8, '1);
        send_frame(4'd6, {16'hDEAD, TAIL_MARK, 16'h0102});
        // too few bytes after the payload for a tail
        send_frame(4'd8, head_bytes(16'd2, 16'h1234));
        send_frame(4'd5, 64'h0000_00CC_66CC_1122);
        send_frame(4'd8, head_bytes(16'd1, 16'h1234));
        send_frame(4'd8, {TAIL_MARK ^ 32'h1, 32'h0});
        send_frame(4'd8, head_bytes(16'd4, 16'h1234));
        send_frame(4'd12, {TAIL_MARK, 32'h8000_0001});
        send_frame(4'd8, head_bytes(16'd0, 16'h1234));
        send_frame(4'd3, 64'hFF);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        apply_config(16'hFFFF, 8'hFF);
        send_packet(7, 1'b1);
        send_packet(3, 1'b0);
        wait_idle();
        apply_config(16'h0000, 8'h00);
        send_packet(12, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_phase(int idle, int stall, int unsigned target);
        int unsigned goal;
        int unsigned pick;
        int unsigned plen;
        logic [15:0] cmd;
        logic [7:0] key;
        pick = $urandom_range(0, 2);
        cmd = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        pick = $urandom_range(0, 2);
        key = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        apply_config(cmd, key);
        idle_pct = idle;
        stall_pct = stall;
        goal = frames_used + target;
        while (frames_used < goal)
        begin
            pick = $urandom_range(0, 99);
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 400)
                                                : $urandom_range(0, 24);
            if (pick < 75)
                send_packet(plen, $urandom_range(0, 9) < 7);
            else if (pick < 90)
                send_noise();
            else
            begin
                // broken sequence: a head then arbitrary frames
                send_frame(FULL_LEN, head_bytes(16'(plen), model_cmd));
                repeat ($urandom_range(1, 4))
                    send_frame(4'($urandom_range(0, 15)), rand_bytes());
            end
        end
        wait_idle();
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_phase(0, 0, 175);
        test_random_phase(70, 0, 175);
        test_random_phase(0, 70, 175);
        test_random_phase(12, 12, 175);
        wait_idle();
        errors += expected_results.size();
        $display("%0d frames sent, %0d results checked, %0d mismatches",
                 frames_sent, results_seen, mismatches);
        $display("packets opened %0d, completed %0d, dropped %0d",
                 heads_seen, packets_done, packets_dropped);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cpd_pkg.sv
rtl/core/cpd_in_reg.sv
rtl/core/cpd_engine.sv
rtl/core/can_packet_deframer.sv
dv/testbench.sv
